>>> src/symmetric_band_matvec_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the symmetric band matrix-vector unit
// Same-cycle and next-cycle implication forms, clocked on clk; the masked forms
// are disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SYMMETRIC_BAND_MATVEC_UNIT_ASSERT_SVH
`define SYMMETRIC_BAND_MATVEC_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SBM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SBM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle form that stays active during reset.
`define SBM_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/sbm_pkg.sv
// ----------------------------------------------------------------------------
// sbm_pkg
// Shared types, widths and codes of the symmetric band matrix-vector unit.
// ----------------------------------------------------------------------------
package sbm_pkg;

  localparam int MAX_ROWS_DEF  = 1024;
  localparam int MAX_BANDS_DEF = 4;

  // Field widths of the beats and the configuration registers.
  localparam int MODE_W       = 2;
  localparam int ROW_FIELD_W  = 10;
  localparam int BAND_FIELD_W = 2;
  localparam int VALUE_W      = 32;
  localparam int ROW_COUNT_W  = 11;
  localparam int BAND_COUNT_W = 3;
  localparam int OFFSET_W     = 11;
  localparam int NUM_OFFSETS  = 4;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 11;

  // Q16.16 operands, Q32.32 products and Q32.16 accumulators.
  localparam int FRAC_W = 16;
  localparam int PROD_W = 2 * VALUE_W;
  localparam int ACC_W  = PROD_W - FRAC_W;

  typedef logic [MODE_W-1:0]              mode_t;
  typedef logic [ROW_FIELD_W-1:0]         row_field_t;
  typedef logic [BAND_FIELD_W-1:0]        band_field_t;
  typedef logic signed [VALUE_W-1:0]      value_t;
  typedef logic                           status_t;
  typedef logic signed [ACC_W-1:0]        acc_t;
  typedef logic [CFG_IDX_W-1:0]           cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]          cfg_data_t;

  localparam mode_t MODE_WR_MATRIX = 2'd0;
  localparam mode_t MODE_WR_VECTOR = 2'd1;
  localparam mode_t MODE_RUN       = 2'd2;
  localparam mode_t MODE_RD_RESULT = 2'd3;

  localparam status_t STATUS_OK    = 1'b0;
  localparam status_t STATUS_RANGE = 1'b1;

  localparam cfg_idx_t CFG_ROW_COUNT     = 3'd0;
  localparam cfg_idx_t CFG_BAND_COUNT    = 3'd1;
  localparam cfg_idx_t CFG_BAND_OFFSET_0 = 3'd2;
  localparam cfg_idx_t CFG_BAND_OFFSET_1 = 3'd3;
  localparam cfg_idx_t CFG_BAND_OFFSET_2 = 3'd4;
  localparam cfg_idx_t CFG_BAND_OFFSET_3 = 3'd5;

endpackage

>>> src/sbm_in_if.sv
// ----------------------------------------------------------------------------
// sbm_in_if
// Command channel: valid/ready handshake with mode, row, band and value.
// ----------------------------------------------------------------------------
interface sbm_in_if;
  import sbm_pkg::*;

  logic        valid;
  logic        ready;
  mode_t       mode;
  row_field_t  row;
  band_field_t band;
  value_t      value;

  modport source (output valid, output mode, output row, output band, output value,
                  input ready);
  modport sink   (input valid, input mode, input row, input band, input value,
                  output ready);
endinterface

>>> src/sbm_out_if.sv
// ----------------------------------------------------------------------------
// sbm_out_if
// Result channel: valid/ready handshake with status and result value.
// ----------------------------------------------------------------------------
interface sbm_out_if;
  import sbm_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  value_t  result_value;

  modport source (output valid, output status, output result_value, input ready);
  modport sink   (input valid, input status, input result_value, output ready);
endinterface

>>> src/sbm_mul.sv
// ----------------------------------------------------------------------------
// sbm_mul
// Two Q16.16 multipliers sharing the matrix entry, each followed by a
// register holding the product floored to Q32.16.
// ----------------------------------------------------------------------------
module sbm_mul (
  input  logic           clk,
  input  logic           load,
  input  sbm_pkg::value_t a,
  input  sbm_pkg::value_t x_col,
  input  sbm_pkg::value_t x_row,
  output sbm_pkg::acc_t   term_col,
  output sbm_pkg::acc_t   term_row
);
  import sbm_pkg::*;

  logic signed [PROD_W-1:0] prod_col;
  logic signed [PROD_W-1:0] prod_row;
  acc_t                     term_col_r;
  acc_t                     term_row_r;

  assign prod_col = a * x_col;
  assign prod_row = a * x_row;

  // Dropping the low fraction bits of the two's complement product rounds
  // toward minus infinity.
  always_ff @(posedge clk) begin
    if (load) begin
      term_col_r <= prod_col[PROD_W-1:FRAC_W];
      term_row_r <= prod_row[PROD_W-1:FRAC_W];
    end
  end

  assign term_col = term_col_r;
  assign term_row = term_row_r;
endmodule

>>> src/symmetric_band_matvec_unit.sv
// ----------------------------------------------------------------------------
// symmetric_band_matvec_unit
// Symmetric banded matrix times vector in Q16.16 with saturating Q32.16
// accumulators held in on-chip memories.
// ----------------------------------------------------------------------------
// Every command beat returns exactly one result beat. Matrix and vector writes
// answer in the cycle after acceptance, result reads after ST_RDWAIT. A run
// first clears the MAX_ROWS accumulators (one per cycle), then walks each row
// in use: ST_ROW and ST_ROWLAT fetch its vector element, then for each band in
// use ST_BAND skips a column outside the matrix, ST_BAND, ST_MUL and ST_ACC1
// serve an entry that only updates its own row, and ST_ACC2 follows when it
// also updates the mirrored row; a last ST_BAND closes each row and a last
// ST_ROW the run. The walk is bounded by the accumulator memory doing one
// read-modify-write at a time. After reset the same clearing pass runs before
// the first command is taken; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module symmetric_band_matvec_unit #(
  parameter int MAX_ROWS  = sbm_pkg::MAX_ROWS_DEF,
  parameter int MAX_BANDS = sbm_pkg::MAX_BANDS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  sbm_in_if.sink              in_chan,
  sbm_out_if.source           out_chan,
  input  logic                cfg_we,
  input  sbm_pkg::cfg_idx_t   cfg_index,
  input  sbm_pkg::cfg_data_t  cfg_data
);
  import sbm_pkg::*;

  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int CNT_W      = $clog2(MAX_ROWS + 1);
  localparam int CMP_W      = (CNT_W > ROW_COUNT_W) ? CNT_W : ROW_COUNT_W;
  localparam int JW         = CMP_W + 2;
  localparam int BAND_DEPTH = MAX_ROWS * MAX_BANDS;
  localparam int BADDR_W    = $clog2(BAND_DEPTH);
  localparam int BAND_CAP   = (MAX_BANDS < NUM_OFFSETS) ? MAX_BANDS : NUM_OFFSETS;

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] ST_IDLE   = 4'd0;
  localparam logic [ST_W-1:0] ST_CLEAR  = 4'd1;
  localparam logic [ST_W-1:0] ST_ROW    = 4'd2;
  localparam logic [ST_W-1:0] ST_ROWLAT = 4'd3;
  localparam logic [ST_W-1:0] ST_BAND   = 4'd4;
  localparam logic [ST_W-1:0] ST_MUL    = 4'd5;
  localparam logic [ST_W-1:0] ST_ACC1   = 4'd6;
  localparam logic [ST_W-1:0] ST_ACC2   = 4'd7;
  localparam logic [ST_W-1:0] ST_RDWAIT = 4'd8;

  localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam value_t RES_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam value_t RES_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  function automatic acc_t sat_add(input acc_t acc, input acc_t term);
    logic signed [ACC_W:0] s;
    s = {acc[ACC_W-1], acc} + {term[ACC_W-1], term};
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? ACC_MIN : ACC_MAX;
    end
    return s[ACC_W-1:0];
  endfunction

  function automatic value_t sat_res(input acc_t acc);
    logic [ACC_W-VALUE_W:0] top;
    top = acc[ACC_W-1:VALUE_W-1];
    if ((&top) || !(|top)) begin
      return acc[VALUE_W-1:0];
    end
    return acc[ACC_W-1] ? RES_MIN : RES_MAX;
  endfunction

  // Configuration registers.
  logic [ROW_COUNT_W-1:0]     row_count_r;
  logic [BAND_COUNT_W-1:0]    band_count_r;
  logic signed [OFFSET_W-1:0] band_offset_r [NUM_OFFSETS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r  <= ROW_COUNT_W'(1);
      band_count_r <= BAND_COUNT_W'(1);
      for (int b = 0; b < NUM_OFFSETS; b++) begin
        band_offset_r[b] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROW_COUNT:     row_count_r      <= cfg_data[ROW_COUNT_W-1:0];
        CFG_BAND_COUNT:    band_count_r     <= cfg_data[BAND_COUNT_W-1:0];
        CFG_BAND_OFFSET_0: band_offset_r[0] <= cfg_data[OFFSET_W-1:0];
        CFG_BAND_OFFSET_1: band_offset_r[1] <= cfg_data[OFFSET_W-1:0];
        CFG_BAND_OFFSET_2: band_offset_r[2] <= cfg_data[OFFSET_W-1:0];
        CFG_BAND_OFFSET_3: band_offset_r[3] <= cfg_data[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // Sizes in use.
  logic [CMP_W-1:0]        row_count_ext;
  logic [CNT_W-1:0]        n_rows;
  logic [BAND_COUNT_W-1:0] n_bands;

  assign row_count_ext = CMP_W'(row_count_r);
  assign n_rows  = (row_count_ext > CMP_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS)
                                                      : CNT_W'(row_count_ext);
  assign n_bands = (band_count_r > BAND_COUNT_W'(BAND_CAP)) ? BAND_COUNT_W'(BAND_CAP)
                                                            : band_count_r;

  // Control and payload registers.
  logic [ST_W-1:0]         state_r, state_nxt;
  logic [ROW_W-1:0]        clr_cnt_r, clr_cnt_nxt;
  logic                    run_pend_r, run_pend_nxt;
  logic [CNT_W-1:0]        i_r, i_nxt;
  logic [BAND_COUNT_W-1:0] k_r, k_nxt;
  logic                    mirror_r, mirror_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [ROW_W-1:0]        j_r, j_nxt;
  value_t                  xi_r, xi_nxt;
  status_t                 out_status_r, out_status_nxt;
  value_t                  out_result_value_r, out_result_value_nxt;

  // Memory ports.
  value_t              band_mem [BAND_DEPTH];
  value_t              vec_mem  [MAX_ROWS];
  acc_t                prod_mem [MAX_ROWS];
  logic                band_we, vec_we, prod_we;
  logic [BADDR_W-1:0]  band_waddr, band_raddr;
  logic [ROW_W-1:0]    vec_waddr, vec_raddr, prod_waddr, prod_raddr;
  acc_t                prod_wdata;
  value_t              band_rdata_r, vec_rdata_r;
  acc_t                prod_rdata_r;

  // Handshake.
  logic in_acc, out_acc;
  assign in_chan.ready = (state_r == ST_IDLE) && (!out_valid_r || out_chan.ready);
  assign in_acc  = in_chan.valid && in_chan.ready;
  assign out_acc = out_valid_r && out_chan.ready;

  // Command decode.
  logic [CMP_W-1:0]   in_row_ext;
  logic [ROW_W-1:0]   in_row_ix;
  logic               row_ok, band_ok;
  logic [BADDR_W:0]   in_baddr_full;

  assign in_row_ext    = CMP_W'(in_chan.row);
  assign in_row_ix     = in_row_ext[ROW_W-1:0];
  assign row_ok        = in_row_ext < CMP_W'(n_rows);
  assign band_ok       = BAND_COUNT_W'(in_chan.band) < n_bands;
  assign in_baddr_full = (BADDR_W+1)'(in_row_ix) * (BADDR_W+1)'(MAX_BANDS)
                       + (BADDR_W+1)'(in_chan.band);

  // Walk addressing: column of the current entry and its range check.
  logic [ROW_W-1:0]           i_ix;
  logic signed [OFFSET_W-1:0] cur_off;
  logic signed [JW-1:0]       j_full, n_signed;
  logic                       j_ok;
  logic [BADDR_W:0]           run_baddr_full;

  assign i_ix     = i_r[ROW_W-1:0];
  assign cur_off  = band_offset_r[k_r[1:0]];
  assign j_full   = $signed(JW'(i_r)) + JW'(cur_off);
  assign n_signed = $signed(JW'(n_rows));
  assign j_ok     = !j_full[JW-1] && (j_full < n_signed);
  assign run_baddr_full = (BADDR_W+1)'(i_ix) * (BADDR_W+1)'(MAX_BANDS)
                        + (BADDR_W+1)'(k_r);

  // Product terms.
  logic mul_load;
  acc_t term_col, term_row;

  sbm_mul u_mul (
    .clk      (clk),
    .load     (mul_load),
    .a        (band_rdata_r),
    .x_col    (vec_rdata_r),
    .x_row    (xi_r),
    .term_col (term_col),
    .term_row (term_row)
  );

  always_comb begin
    state_nxt            = state_r;
    clr_cnt_nxt          = clr_cnt_r;
    run_pend_nxt         = run_pend_r;
    i_nxt                = i_r;
    k_nxt                = k_r;
    mirror_nxt           = mirror_r;
    j_nxt                = j_r;
    xi_nxt               = xi_r;
    out_valid_nxt        = out_acc ? 1'b0 : out_valid_r;
    out_status_nxt       = out_status_r;
    out_result_value_nxt = out_result_value_r;

    band_we    = 1'b0;
    band_waddr = in_baddr_full[BADDR_W-1:0];
    band_raddr = run_baddr_full[BADDR_W-1:0];
    vec_we     = 1'b0;
    vec_waddr  = in_row_ix;
    vec_raddr  = (state_r == ST_ROW) ? i_ix : j_full[ROW_W-1:0];
    prod_we    = 1'b0;
    prod_waddr = i_ix;
    prod_wdata = '0;
    prod_raddr = i_ix;
    mul_load   = 1'b0;

    case (state_r)
      ST_IDLE: begin
        prod_raddr = in_row_ix;
        if (in_acc) begin
          case (in_chan.mode)
            MODE_WR_MATRIX: begin
              band_we              = row_ok && band_ok;
              out_valid_nxt        = 1'b1;
              out_status_nxt       = (row_ok && band_ok) ? STATUS_OK : STATUS_RANGE;
              out_result_value_nxt = '0;
            end
            MODE_WR_VECTOR: begin
              vec_we               = row_ok;
              out_valid_nxt        = 1'b1;
              out_status_nxt       = row_ok ? STATUS_OK : STATUS_RANGE;
              out_result_value_nxt = '0;
            end
            MODE_RUN: begin
              run_pend_nxt = 1'b1;
              state_nxt    = ST_CLEAR;
            end
            MODE_RD_RESULT: begin
              if (row_ok) begin
                state_nxt = ST_RDWAIT;
              end else begin
                out_valid_nxt        = 1'b1;
                out_status_nxt       = STATUS_RANGE;
                out_result_value_nxt = '0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CLEAR: begin
        prod_we     = 1'b1;
        prod_waddr  = clr_cnt_r;
        prod_wdata  = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == ROW_W'(MAX_ROWS - 1)) begin
          clr_cnt_nxt  = '0;
          run_pend_nxt = 1'b0;
          i_nxt        = '0;
          state_nxt    = run_pend_r ? ST_ROW : ST_IDLE;
        end
      end
      ST_RDWAIT: begin
        out_valid_nxt        = 1'b1;
        out_status_nxt       = STATUS_OK;
        out_result_value_nxt = sat_res(prod_rdata_r);
        state_nxt            = ST_IDLE;
      end
      ST_ROW: begin
        if (i_r == n_rows) begin
          out_valid_nxt        = 1'b1;
          out_status_nxt       = STATUS_OK;
          out_result_value_nxt = '0;
          state_nxt            = ST_IDLE;
        end else begin
          k_nxt     = '0;
          state_nxt = ST_ROWLAT;
        end
      end
      ST_ROWLAT: begin
        xi_nxt    = vec_rdata_r;
        state_nxt = ST_BAND;
      end
      ST_BAND: begin
        if (k_r == n_bands) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_ROW;
        end else if (!j_ok) begin
          k_nxt = k_r + 1'b1;
        end else begin
          j_nxt      = j_full[ROW_W-1:0];
          mirror_nxt = cur_off[OFFSET_W-1];
          state_nxt  = ST_MUL;
        end
      end
      ST_MUL: begin
        mul_load  = 1'b1;
        state_nxt = ST_ACC1;
      end
      ST_ACC1: begin
        // The mirrored row is read while the own row is written; the two
        // never coincide because a mirrored entry has a negative offset.
        prod_we    = 1'b1;
        prod_waddr = i_ix;
        prod_wdata = sat_add(prod_rdata_r, term_col);
        prod_raddr = j_r;
        if (mirror_r) begin
          state_nxt = ST_ACC2;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = ST_BAND;
        end
      end
      ST_ACC2: begin
        prod_we    = 1'b1;
        prod_waddr = j_r;
        prod_wdata = sat_add(prod_rdata_r, term_row);
        k_nxt      = k_r + 1'b1;
        state_nxt  = ST_BAND;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      run_pend_r  <= 1'b0;
      i_r         <= '0;
      k_r         <= '0;
      mirror_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      run_pend_r  <= run_pend_nxt;
      i_r         <= i_nxt;
      k_r         <= k_nxt;
      mirror_r    <= mirror_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r                <= j_nxt;
    xi_r               <= xi_nxt;
    out_status_r       <= out_status_nxt;
    out_result_value_r <= out_result_value_nxt;
  end

  always_ff @(posedge clk) begin
    if (band_we) begin
      band_mem[band_waddr] <= in_chan.value;
    end
    band_rdata_r <= band_mem[band_raddr];
  end

  always_ff @(posedge clk) begin
    if (vec_we) begin
      vec_mem[vec_waddr] <= in_chan.value;
    end
    vec_rdata_r <= vec_mem[vec_raddr];
  end

  always_ff @(posedge clk) begin
    if (prod_we) begin
      prod_mem[prod_waddr] <= prod_wdata;
    end
    prod_rdata_r <= prod_mem[prod_raddr];
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = out_status_r;
  assign out_chan.result_value = out_result_value_r;
endmodule

>>> src/sbm_checker.sv
// ----------------------------------------------------------------------------
// sbm_checker
// Port-level checks of the symmetric band matrix-vector unit, bound to the
// top level.
// ----------------------------------------------------------------------------
`include "symmetric_band_matvec_unit_assert.svh"

module sbm_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input sbm_pkg::status_t out_status,
  input sbm_pkg::value_t  out_result_value
);
  logic       in_accept, out_accept;
  logic [1:0] outstanding_r, outstanding_nxt;

  assign in_accept  = in_valid && in_ready;
  assign out_accept = out_valid && out_ready;

  // Beats taken in whose result beat has not yet gone out.
  always_comb begin
    outstanding_nxt = outstanding_r;
    if (in_accept && !out_accept) begin
      outstanding_nxt = outstanding_r + 2'd1;
    end else if (out_accept && !in_accept) begin
      outstanding_nxt = outstanding_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outstanding_r <= 2'd0;
    end else begin
      outstanding_r <= outstanding_nxt;
    end
  end

  `SBM_ASSERT_NEXT_ALWAYS(a_clear_after_reset, !rst_n, !in_ready, "input taken during clearing pass")
  `SBM_ASSERT_NOW(a_one_in_flight, in_accept, (outstanding_r == 2'd0) || out_accept, "second beat taken while one is pending")
  `SBM_ASSERT_NOW(a_no_spurious_result, out_valid, outstanding_r != 2'd0, "result beat without a pending command")
  `SBM_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_result_value), "stalled result beat changed")
endmodule

bind symmetric_band_matvec_unit sbm_checker u_sbm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_chan.valid),
  .in_ready         (in_chan.ready),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_status       (out_chan.status),
  .out_result_value (out_chan.result_value)
);

>>> test/sbm_product_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Symmetric band matrix-vector result checker
// Watches the command, result and register ports of the unit. It keeps its own
// copy of the band, vector and accumulator memories, works out the answer to
// every accepted command beat, and compares each accepted result beat field by
// field with the oldest answer still waiting.
// ----------------------------------------------------------------------------
module sbm_product_checker
  import sbm_pkg::*;
#(
  parameter int ROWS  = MAX_ROWS_DEF,
  parameter int BANDS = MAX_BANDS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  sbm_in_if         cmd,
  sbm_out_if        res,
  input  logic      cfg_we,
  input  cfg_idx_t  cfg_index,
  input  cfg_data_t cfg_data,
  output int        mismatches,
  output int        outstanding,
  output int        compared,
  output int        rejected,
  output int        clipped
);

  typedef struct packed {
    status_t status;
    value_t  value;
  } answer_t;

  localparam longint ACC_HI = (64'sd1 <<< (ACC_W - 1)) - 64'sd1;
  localparam longint ACC_LO = -(64'sd1 <<< (ACC_W - 1));
  localparam longint OUT_HI = 64'sh7FFF_FFFF;
  localparam longint OUT_LO = -64'sh8000_0000;

  logic [ROW_COUNT_W-1:0]     row_count_r;
  logic [BAND_COUNT_W-1:0]    band_count_r;
  logic signed [OFFSET_W-1:0] offset_r [NUM_OFFSETS];

  value_t band_mem [ROWS*BANDS];
  value_t elem_mem [ROWS];
  acc_t   acc_mem  [ROWS];

  answer_t pending_answers [$];
  answer_t oldest;
  answer_t fresh;

  function automatic int rows_used();
    return (row_count_r < ROWS) ? int'(row_count_r) : ROWS;
  endfunction

  function automatic int bands_used();
    int b;
    b = int'(band_count_r);
    if (b > BANDS) b = BANDS;
    if (b > NUM_OFFSETS) b = NUM_OFFSETS;
    return b;
  endfunction

  // Full Q16.16 product, floored back to sixteen fraction bits.
  function automatic acc_t q16_product(value_t a, value_t b);
    logic signed [PROD_W-1:0] p;
    p = a * b;
    return acc_t'(p >>> FRAC_W);
  endfunction

  function automatic acc_t acc_sat_add(acc_t acc, acc_t term);
    longint s;
    s = longint'(acc) + longint'(term);
    if (s > ACC_HI) s = ACC_HI;
    if (s < ACC_LO) s = ACC_LO;
    return acc_t'(s);
  endfunction

  function automatic void run_matvec();
    int n;
    int d;
    int j;
    value_t a;
    for (int r = 0; r < ROWS; r++) acc_mem[r] = '0;
    n = rows_used();
    d = bands_used();
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < d; k++) begin
        j = i + int'(offset_r[k]);
        if (j >= 0 && j < n) begin
          a = band_mem[i*BANDS + k];
          acc_mem[i] = acc_sat_add(acc_mem[i], q16_product(a, elem_mem[j]));
          // Lower-band entries stand in for their mirror above the diagonal.
          if (offset_r[k] < 0) acc_mem[j] = acc_sat_add(acc_mem[j], q16_product(a, elem_mem[i]));
        end
      end
    end
  endfunction

  function automatic answer_t predict_answer(mode_t m, row_field_t r, band_field_t b, value_t v);
    answer_t ans;
    longint acc_val;
    ans.status = STATUS_OK;
    ans.value  = '0;
    case (m)
      MODE_WR_MATRIX: begin
        if (int'(r) >= rows_used() || int'(b) >= bands_used()) ans.status = STATUS_RANGE;
        else band_mem[int'(r)*BANDS + int'(b)] = v;
      end
      MODE_WR_VECTOR: begin
        if (int'(r) >= rows_used()) ans.status = STATUS_RANGE;
        else elem_mem[r] = v;
      end
      MODE_RUN: begin
        run_matvec();
      end
      default: begin
        if (int'(r) >= rows_used()) begin
          ans.status = STATUS_RANGE;
        end else begin
          acc_val = longint'(acc_mem[r]);
          if (acc_val > OUT_HI || acc_val < OUT_LO) clipped++;
          if (acc_val > OUT_HI) acc_val = OUT_HI;
          if (acc_val < OUT_LO) acc_val = OUT_LO;
          ans.value = value_t'(acc_val);
        end
      end
    endcase
    return ans;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      row_count_r  = ROW_COUNT_W'(1);
      band_count_r = BAND_COUNT_W'(1);
      for (int k = 0; k < NUM_OFFSETS; k++) offset_r[k] = '0;
      for (int r = 0; r < ROWS; r++) acc_mem[r] = '0;
      pending_answers.delete();
      mismatches = 0;
      compared   = 0;
      rejected   = 0;
      clipped    = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ROW_COUNT:     row_count_r  = cfg_data[ROW_COUNT_W-1:0];
          CFG_BAND_COUNT:    band_count_r = cfg_data[BAND_COUNT_W-1:0];
          CFG_BAND_OFFSET_0: offset_r[0]  = cfg_data[OFFSET_W-1:0];
          CFG_BAND_OFFSET_1: offset_r[1]  = cfg_data[OFFSET_W-1:0];
          CFG_BAND_OFFSET_2: offset_r[2]  = cfg_data[OFFSET_W-1:0];
          CFG_BAND_OFFSET_3: offset_r[3]  = cfg_data[OFFSET_W-1:0];
          default: ;
        endcase
      end
      // The result beat at this edge always belongs to an earlier command.
      if (res.valid && res.ready) begin
        if (pending_answers.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with none expected: status %0d value %h", $time,
                   res.status, res.result_value);
        end else begin
          oldest = pending_answers.pop_front();
          compared++;
          if (res.status !== oldest.status) begin
            mismatches++;
            $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                     oldest.status, res.status);
          end
          if (res.result_value !== oldest.value) begin
            mismatches++;
            $display("%0t: value mismatch: expected %h, actual %h", $time,
                     oldest.value, res.result_value);
          end
        end
      end
      if (cmd.valid && cmd.ready) begin
        fresh = predict_answer(cmd.mode, cmd.row, cmd.band, cmd.value);
        if (fresh.status == STATUS_RANGE) rejected++;
        pending_answers = {pending_answers, fresh};
      end
    end
    outstanding = pending_answers.size();
  end

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Symmetric band matrix-vector unit testbench
// Drives command beats in random bursts and drains results with a stalling
// receiver, over many register settings from tiny to full-size sparse ones.
// Every product run only touches matrix and vector entries that were loaded.
// ----------------------------------------------------------------------------
module tb;
  import sbm_pkg::*;

  localparam int ITEM_TARGET = 1250;
  localparam int QUIET_LIMIT = 200000;
  localparam int LONG_STALL  = 300;

  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_style_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      cfg_we;
  cfg_idx_t  cfg_index;
  cfg_data_t cfg_data;

  int mismatches;
  int outstanding;
  int compared;
  int rejected;
  int clipped;

  // Stimulus-side view of the registers and of which entries hold data.
  int cfg_rows;
  int cfg_bands;
  int cfg_off [NUM_OFFSETS];
  bit band_loaded [MAX_ROWS_DEF*MAX_BANDS_DEF];
  bit elem_loaded [MAX_ROWS_DEF];

  int items_sent;
  int products_started;
  int settings_used;
  int burst_left;
  bit long_stall_req;
  bit long_stall_done;
  int phase;

  sbm_in_if  cmd_if ();
  sbm_out_if res_if ();

  symmetric_band_matvec_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (cmd_if),
    .out_chan  (res_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sbm_product_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd_if),
    .res         (res_if),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .compared    (compared),
    .rejected    (rejected),
    .clipped     (clipped)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int rows_active();
    return (cfg_rows < MAX_ROWS_DEF) ? cfg_rows : MAX_ROWS_DEF;
  endfunction

  function automatic int bands_active();
    return (cfg_bands < NUM_OFFSETS) ? cfg_bands : NUM_OFFSETS;
  endfunction

  function automatic value_t pick_value();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 6))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 32'sh0000_0000;
          3: return 32'shFFFF_FFFF;
          4: return 32'sh0000_0001;
          5: return 32'sh0001_0000;
          default: return 32'shFFFF_0000;
        endcase
      end
      1, 2: return value_t'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return value_t'($urandom);
    endcase
  endfunction

  function automatic row_field_t pick_row();
    int n = rows_active();
    if (n > 0 && $urandom_range(0, 7) != 0) return row_field_t'($urandom_range(0, n - 1));
    return row_field_t'($urandom_range(0, MAX_ROWS_DEF - 1));
  endfunction

  function automatic band_field_t pick_band();
    int d = bands_active();
    if (d > 0 && $urandom_range(0, 5) != 0) return band_field_t'($urandom_range(0, d - 1));
    return band_field_t'($urandom_range(0, 3));
  endfunction

  function automatic int far_offset();
    case ($urandom_range(0, 6))
      0: return -1024;
      1: return -1023;
      2: return -1022;
      3: return -1016;
      4: return 1016;
      5: return 1022;
      default: return 1023;
    endcase
  endfunction

  task automatic send_cmd(mode_t m, row_field_t r, band_field_t b, value_t v);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 80 : 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        cmd_if.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    cmd_if.valid = 1'b1;
    cmd_if.mode  = m;
    cmd_if.row   = r;
    cmd_if.band  = b;
    cmd_if.value = v;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    items_sent++;
    if (m == MODE_WR_MATRIX && int'(r) < rows_active() && int'(b) < bands_active())
      band_loaded[int'(r)*MAX_BANDS_DEF + int'(b)] = 1'b1;
    if (m == MODE_WR_VECTOR && int'(r) < rows_active()) elem_loaded[r] = 1'b1;
  endtask

  task automatic settle();
    @(negedge clk);
    cmd_if.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_register(cfg_idx_t idx, int data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = cfg_data_t'(data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic program_setting(int n, int d, int o0, int o1, int o2, int o3);
    cfg_rows   = n;
    cfg_bands  = d;
    cfg_off[0] = o0;
    cfg_off[1] = o1;
    cfg_off[2] = o2;
    cfg_off[3] = o3;
    set_register(CFG_ROW_COUNT, n);
    set_register(CFG_BAND_COUNT, d);
    set_register(CFG_BAND_OFFSET_0, o0);
    set_register(CFG_BAND_OFFSET_1, o1);
    set_register(CFG_BAND_OFFSET_2, o2);
    set_register(CFG_BAND_OFFSET_3, o3);
    settings_used++;
  endtask

  // Before a product, load every entry the walk will touch that holds no data.
  task automatic start_product();
    int n;
    int d;
    int j;
    n = rows_active();
    d = bands_active();
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < d; k++) begin
        j = i + cfg_off[k];
        if (j >= 0 && j < n) begin
          if (!band_loaded[i*MAX_BANDS_DEF + k])
            send_cmd(MODE_WR_MATRIX, row_field_t'(i), band_field_t'(k), pick_value());
          if (!elem_loaded[j])
            send_cmd(MODE_WR_VECTOR, row_field_t'(j), band_field_t'($urandom_range(0, 3)),
                     pick_value());
          if (cfg_off[k] < 0 && !elem_loaded[i])
            send_cmd(MODE_WR_VECTOR, row_field_t'(i), band_field_t'($urandom_range(0, 3)),
                     pick_value());
        end
      end
    end
    send_cmd(MODE_RUN, row_field_t'($urandom), band_field_t'($urandom), value_t'($urandom));
    products_started++;
  endtask

  task automatic product_sequence(int n_writes);
    int n;
    n = rows_active();
    repeat (n_writes) begin
      if ($urandom_range(0, 1) == 0) send_cmd(MODE_WR_MATRIX, pick_row(), pick_band(), pick_value());
      else send_cmd(MODE_WR_VECTOR, pick_row(), band_field_t'($urandom), pick_value());
    end
    start_product();
    if (n <= 24) begin
      for (int i = 0; i < n; i++)
        send_cmd(MODE_RD_RESULT, row_field_t'(i), band_field_t'($urandom), value_t'($urandom));
    end else begin
      send_cmd(MODE_RD_RESULT, '0, band_field_t'($urandom), value_t'($urandom));
      send_cmd(MODE_RD_RESULT, row_field_t'(n - 1), band_field_t'($urandom), value_t'($urandom));
      repeat (14)
        send_cmd(MODE_RD_RESULT, row_field_t'($urandom_range(0, n - 1)), band_field_t'($urandom),
                 value_t'($urandom));
    end
    if (n < MAX_ROWS_DEF && $urandom_range(0, 2) == 0)
      send_cmd(MODE_RD_RESULT, row_field_t'($urandom_range(n, MAX_ROWS_DEF - 1)),
               band_field_t'($urandom), value_t'($urandom));
  endtask

  task automatic noise_sequence(int count);
    mode_t m;
    repeat (count) begin
      m = mode_t'($urandom_range(0, 3));
      if (m == MODE_RUN) start_product();
      else send_cmd(m, pick_row(), pick_band(), pick_value());
    end
  endtask

  // Small matrices mostly; now and then a full-size one with far diagonals only.
  task automatic pick_setting(int ph);
    int n;
    int d;
    int sel;
    int o [NUM_OFFSETS];
    sel = $urandom_range(0, 19);
    if (ph == 0) begin
      n = 2047;
      d = 4;
      o = '{-1023, 1023, -1024, -1022};
    end else if (ph == 1 || sel == 0) begin
      n = ($urandom_range(0, 1) == 0) ? MAX_ROWS_DEF : $urandom_range(MAX_ROWS_DEF + 1, 2047);
      d = $urandom_range(1, 7);
      for (int k = 0; k < NUM_OFFSETS; k++) o[k] = far_offset();
    end else begin
      n = (sel < 16) ? $urandom_range(1, 16) : $urandom_range(17, 64);
      case ($urandom_range(0, 15))
        0: d = 0;
        1: d = $urandom_range(5, 7);
        default: d = $urandom_range(1, 4);
      endcase
      for (int k = 0; k < NUM_OFFSETS; k++)
        o[k] = ($urandom_range(0, 7) == 0) ? far_offset()
                                           : int'($urandom_range(0, 2*n + 2)) - (n + 1);
      if (sel == 19 && $urandom_range(0, 1) == 0) n = 0;
    end
    program_setting(n, d, o[0], o[1], o[2], o[3]);
  endtask

  initial begin : result_sink
    rx_style_t style;
    int style_left;
    style = RX_OPEN;
    style_left = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_stall_req) begin
        res_if.ready = 1'b0;
        repeat (LONG_STALL) @(negedge clk);
        long_stall_req = 1'b0;
      end
      if (style_left == 0) begin
        style = rx_style_t'($urandom_range(0, 3));
        style_left = $urandom_range(16, 160);
      end
      style_left--;
      case (style)
        RX_OPEN:  res_if.ready = 1'b1;
        RX_LIGHT: res_if.ready = ($urandom_range(0, 3) != 0);
        RX_HEAVY: res_if.ready = ($urandom_range(0, 3) == 0);
        default:  res_if.ready = (style_left % 7) < 3;
      endcase
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    cmd_if.valid = 1'b0;
    cmd_if.mode  = MODE_WR_MATRIX;
    cmd_if.row   = '0;
    cmd_if.band  = '0;
    cmd_if.value = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_ROW_COUNT;
    cfg_data  = '0;
    cfg_rows  = 1;
    cfg_bands = 1;
    for (int k = 0; k < NUM_OFFSETS; k++) cfg_off[k] = 0;
    items_sent = 0;
    products_started = 0;
    settings_used = 0;
    burst_left = 0;
    long_stall_req = 1'b0;
    long_stall_done = 1'b0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset setting: a single row and a single diagonal at offset zero.
    send_cmd(MODE_RD_RESULT, '0, '0, '0);
    send_cmd(MODE_RD_RESULT, 10'd1, '0, '0);
    send_cmd(MODE_WR_MATRIX, '0, 2'd1, 32'sh7FFF_FFFF);
    send_cmd(MODE_WR_VECTOR, '0, 2'd3, 32'sh8000_0000);
    send_cmd(MODE_WR_MATRIX, '0, '0, 32'sh8000_0000);
    start_product();
    send_cmd(MODE_RD_RESULT, '0, '0, '0);
    send_cmd(MODE_WR_VECTOR, 10'd1023, '0, 32'shFFFF_FFFF);
    settle();

    // No rows at all: everything indexed is out of range.
    program_setting(0, 2, 0, 0, 0, 0);
    send_cmd(MODE_WR_VECTOR, '0, '0, 32'sh0001_0000);
    start_product();
    send_cmd(MODE_RD_RESULT, '0, '0, '0);
    settle();

    // No diagonals: the product clears every row to zero.
    program_setting(2, 0, 0, 0, 0, 0);
    send_cmd(MODE_WR_MATRIX, 10'd1, '0, 32'sh0001_0000);
    start_product();
    send_cmd(MODE_RD_RESULT, 10'd1, '0, '0);
    settle();

    // Band count above the maximum clamps to four. Row zero first saturates
    // its accumulator, then two large negative mirror terms pull it back.
    program_setting(4, 7, 0, -1, -2, -3);
    for (int i = 0; i < 4; i++)
      send_cmd(MODE_WR_VECTOR, row_field_t'(i), '0, 32'sh8000_0000);
    send_cmd(MODE_WR_MATRIX, 10'd0, 2'd0, 32'sh8000_0000);
    send_cmd(MODE_WR_MATRIX, 10'd1, 2'd1, 32'sh8000_0000);
    send_cmd(MODE_WR_MATRIX, 10'd2, 2'd2, 32'sh7FFF_FFFF);
    send_cmd(MODE_WR_MATRIX, 10'd3, 2'd3, 32'sh7FFF_FFFF);
    start_product();
    send_cmd(MODE_RD_RESULT, 10'd0, '0, '0);
    send_cmd(MODE_RD_RESULT, 10'd3, '0, '0);
    settle();

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      pick_setting(phase);
      repeat ($urandom_range(2, 4)) begin
        if (phase == 3 && !long_stall_done) begin
          // Results back up while commands keep coming, until the input stalls.
          long_stall_req = 1'b1;
          long_stall_done = 1'b1;
          product_sequence(48);
        end else if ($urandom_range(0, 9) < 7) begin
          product_sequence($urandom_range(1, 10));
        end else begin
          noise_sequence($urandom_range(4, 16));
        end
      end
      settle();
      phase++;
    end

    settle();
    repeat (8) @(posedge clk);
    $display("Covered %0d command beats over %0d register settings, %0d product runs.",
             items_sent, settings_used, products_started);
    $display("Checked %0d results: %0d out-of-range answers, %0d reads clipped to 32 bits.",
             compared, rejected, clipped);
    if (mismatches == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
